FILE: hdl/nps_pkg.sv
package nps_pkg;

  localparam int COORD_W = 16;
  localparam int NIDX_W  = 10;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Depth of the command queue between the front and the search engine.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic [NIDX_W-1:0]         nearest_index;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      table_full;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    vertex_t         pt;
  } cmd_t;

endpackage

FILE: hdl/nps_front.sv
module nps_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  nps_pkg::in_item_t in_data,
  output logic             cmd_valid,
  output nps_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);

  nps_pkg::cmd_t                   q_mem [nps_pkg::CMD_DEPTH];
  logic [nps_pkg::CMD_PTR_W-1:0]   wr_ptr_r;
  logic [nps_pkg::CMD_PTR_W-1:0]   rd_ptr_r;
  logic [nps_pkg::CMD_PTR_W:0]     fill_r;
  logic                            accept;
  logic                            enq;
  logic                            deq;

  assign full      = (fill_r == (nps_pkg::CMD_PTR_W + 1)'(nps_pkg::CMD_DEPTH));
  assign accept    = push && !full;
  // The unused operation code is taken off the channel and dropped here.
  assign enq       = accept && (in_data.operation != nps_pkg::OP_UNUSED);
  assign cmd_valid = (fill_r != '0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (deq) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (enq && !deq) begin
        fill_r <= fill_r + 1'b1;
      end else if (deq && !enq) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr_r] <= '{op: in_data.operation,
                           pt: '{x: in_data.coord_x, y: in_data.coord_y,
                                 z: in_data.coord_z}};
    end
  end

endmodule

FILE: hdl/nps_engine.sv
module nps_engine #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  nps_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               res_push,
  output nps_pkg::out_item_t res_data,
  input  logic               res_full
);

  localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CW     = nps_pkg::COORD_W;
  localparam int SQ_W   = 2 * CW;
  localparam int DIST_W = 2 * CW + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  nps_pkg::vertex_t vmem [MAX_VERTICES];

  logic [1:0]             st_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       scan_cnt_r;
  logic                   rd_v_r;
  logic [IDX_W-1:0]       rd_idx_r;
  nps_pkg::vertex_t       rd_data_r;
  logic                   sq_v_r;
  logic [IDX_W-1:0]       sq_idx_r;
  nps_pkg::vertex_t       sq_data_r;
  logic [SQ_W-1:0]        sqx_r;
  logic [SQ_W-1:0]        sqy_r;
  logic                   have_r;
  logic [DIST_W-1:0]      best_dist_r;
  logic [IDX_W-1:0]       best_idx_r;
  nps_pkg::vertex_t       best_pt_r;
  nps_pkg::vertex_t       q_r;
  nps_pkg::out_item_t     res_r;

  logic                   take_cmd;
  logic                   room;
  logic                   mem_we;
  logic                   scan_issue;
  logic                   scan_done;
  logic                   better;
  logic signed [CW:0]     dx;
  logic signed [CW:0]     dy;
  logic signed [2*CW+1:0] px;
  logic signed [2*CW+1:0] py;
  logic [DIST_W-1:0]      cand_dist;
  logic [IDX_W+nps_pkg::NIDX_W-1:0] idx_ext;

  assign take_cmd   = (st_r == ST_IDLE) && cmd_valid;
  assign cmd_pop    = take_cmd;
  assign room       = (count_r < MAX_CNT);
  assign mem_we     = take_cmd && (cmd.op == nps_pkg::OP_APPEND) && room;
  assign scan_issue = (st_r == ST_SCAN) && (scan_cnt_r != count_r);
  assign scan_done  = (st_r == ST_SCAN) && (scan_cnt_r == count_r) && !rd_v_r && !sq_v_r;
  assign res_push   = (st_r == ST_OUT) && !res_full;
  assign res_data   = res_r;

  // Exact squared differences; each square is below 2**(2*COORD_W).
  assign dx   = (CW + 1)'(rd_data_r.x) - (CW + 1)'(q_r.x);
  assign dy   = (CW + 1)'(rd_data_r.y) - (CW + 1)'(q_r.y);
  assign px   = dx * dx;
  assign py   = dy * dy;
  assign cand_dist = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  // Strict less-than keeps the lowest index on equal distances.
  assign better  = sq_v_r && (!have_r || (cand_dist < best_dist_r));
  assign idx_ext = {{nps_pkg::NIDX_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[count_r[IDX_W-1:0]] <= cmd.pt;
    end
    if (scan_issue) begin
      rd_data_r <= vmem[scan_cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
      rd_v_r  <= 1'b0;
      sq_v_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      rd_v_r <= scan_issue;
      sq_v_r <= rd_v_r;
      unique case (st_r)
        ST_IDLE: begin
          if (take_cmd) begin
            unique case (cmd.op)
              nps_pkg::OP_CLEAR: begin
                count_r <= '0;
              end
              nps_pkg::OP_APPEND: begin
                if (room) begin
                  count_r <= count_r + 1'b1;
                end else begin
                  st_r <= ST_OUT;
                end
              end
              nps_pkg::OP_QUERY: begin
                have_r <= 1'b0;
                st_r   <= (count_r == '0) ? ST_OUT : ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (better) begin
            have_r <= 1'b1;
          end
          if (scan_done) begin
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_full) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd && (cmd.op == nps_pkg::OP_QUERY)) begin
      q_r        <= cmd.pt;
      scan_cnt_r <= '0;
    end else if (scan_issue) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
    rd_idx_r  <= scan_cnt_r[IDX_W-1:0];
    sq_idx_r  <= rd_idx_r;
    sq_data_r <= rd_data_r;
    sqx_r     <= px[SQ_W-1:0];
    sqy_r     <= py[SQ_W-1:0];
    if (better) begin
      best_dist_r <= cand_dist;
      best_idx_r  <= sq_idx_r;
      best_pt_r   <= sq_data_r;
    end
    if (take_cmd && (cmd.op == nps_pkg::OP_APPEND) && !room) begin
      res_r <= '{found: 1'b0, nearest_index: '0, out_x: '0, out_y: '0,
                 out_z: '0, table_full: 1'b1};
    end else if (take_cmd && (cmd.op == nps_pkg::OP_QUERY) && (count_r == '0)) begin
      res_r <= '{found: 1'b0, nearest_index: '0, out_x: cmd.pt.x,
                 out_y: cmd.pt.y, out_z: cmd.pt.z, table_full: 1'b0};
    end else if (scan_done) begin
      res_r <= '{found: 1'b1, nearest_index: idx_ext[nps_pkg::NIDX_W-1:0],
                 out_x: best_pt_r.x, out_y: best_pt_r.y, out_z: best_pt_r.z,
                 table_full: 1'b0};
    end
  end

endmodule

FILE: hdl/nps_result_buf.sv
module nps_result_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_push,
  input  nps_pkg::out_item_t res_data,
  output logic               res_full,
  output logic               empty,
  input  logic               pop,
  output nps_pkg::out_item_t out_data
);

  nps_pkg::out_item_t slot_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         fill_r;
  logic               enq;
  logic               deq;

  assign res_full = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign enq      = res_push && !res_full;
  assign deq      = pop && !empty;
  assign out_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (enq && !deq) begin
        fill_r <= fill_r + 1'b1;
      end else if (deq && !enq) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slot_r[wr_ptr_r] <= res_data;
    end
  end

endmodule

FILE: hdl/nearest_point_search_2d.sv
// Channel   Handshake              Payload                Direction
// input     push / full            nps_pkg::in_item_t     into the block
// result    empty / pop            nps_pkg::out_item_t    out of the block
//
// A clear or an append is registered in the command queue before it reaches the engine.
// In a query the single read port of the vertex memory delivers one vertex per cycle
// into a square-and-compare pipeline. Synchronous active-low reset empties both queues
// and the table at once. The input queues up to four commands while the engine is busy;
// the engine waits when the two-entry result buffer is full.
module nearest_point_search_2d #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  nps_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output nps_pkg::out_item_t out_data
);

  logic               cmd_valid;
  nps_pkg::cmd_t      cmd;
  logic               cmd_pop;
  logic               res_push;
  nps_pkg::out_item_t res_data;
  logic               res_full;

  nps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  nps_engine #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  nps_result_buf u_result_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full result buffer");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("engine took a command from an empty queue");

  a_full_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_data.table_full) |->
      (!res_data.found && (res_data.nearest_index == '0)))
    else $error("dropped-load result carries a match");

endmodule
